@@ rtl/core/assert_macros.svh @@
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk_i, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/lrd_pkg.sv @@
// Shared types, codes and the CRC table for the log record deframer.
package lrd_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] AllOnes = 32'hFFFFFFFF;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW = 2;

  typedef enum logic [2:0] {
    KIND_OPCODE  = 3'd0,
    KIND_ARGLEN  = 3'd1,
    KIND_ARGBYTE = 3'd2,
    KIND_VERDICT = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  localparam logic [1:0] VerdictOk = 2'd0;
  localparam logic [1:0] VerdictMalformed = 2'd1;
  localparam logic [1:0] VerdictCrcBad = 2'd2;
  localparam logic [1:0] EndClean = 2'd0;
  localparam logic [1:0] EndPartial = 2'd1;
  localparam logic [1:0] EndCrc = 2'd2;
  localparam logic [1:0] EndShortTail = 2'd3;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_OPCODE  = 7'b0000010,
    PH_NARGS   = 7'b0000100,
    PH_ARGLEN  = 7'b0001000,
    PH_ARGBYTE = 7'b0010000,
    PH_SKIP    = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  // One word of results caused by one log byte: up to three, in order.
  typedef struct packed {
    logic [1:0]  count;
    result_t [2:0] res;
  } bundle_t;

  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    return (c >> 8) ^ crc_entry(c[7:0] ^ b);
  endfunction

endpackage

@@ rtl/core/lrd_front.sv @@
// Front end: tracks record framing and CRC, builds the results of each log byte.
module lrd_front import lrd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   log_length_i,
  input  logic          take_i,
  input  logic [7:0]    log_byte_i,
  output bundle_t       bundle_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d, start_q, start_d, pleft_q, pleft_d, stored_q, stored_d;
  logic [31:0] crc_q, crc_d, args_q, args_d, abytes_q, abytes_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic        mal_q, mal_d;

  always_comb begin
    logic [2:0]  hidx;
    logic [31:0] rem;
    logic [31:0] sh;
    logic [32:0] endpos;
    logic        fin;
    bundle_o = '0;
    phase_d = phase_q; pos_d = pos_q; start_d = start_q; pleft_d = pleft_q;
    stored_d = stored_q; crc_d = crc_q; args_d = args_q; abytes_d = abytes_q;
    fcnt_d = fcnt_q; mal_d = mal_q;
    hidx = 3'(pos_q - start_q);
    rem = '0; sh = '0; endpos = '0; fin = 1'b0;
    unique case (phase_q)
      PH_DONE: ;
      PH_HEADER: begin
        rem = (pos_q < log_length_i) ? (log_length_i - pos_q) : 32'd0;
        if (hidx == 3'd0 && rem < 32'd8) begin
          bundle_o.count = 2'd1;
          bundle_o.res[0] = '{KIND_END, log_length_i,
                              (rem == 32'd0) ? EndClean : EndShortTail};
          phase_d = PH_DONE;
        end else begin
          sh = 32'(log_byte_i) << {hidx[1:0], 3'd0};
          if (!hidx[2]) pleft_d = pleft_q | sh;
          else stored_d = stored_q | sh;
          pos_d = pos_q + 32'd1;
          if (hidx == 3'd7) begin
            fcnt_d = '0;
            endpos = {1'b0, start_q} + 33'd8 + {1'b0, pleft_q};
            if (endpos > {1'b0, log_length_i}) begin
              bundle_o.count = 2'd1;
              bundle_o.res[0] = '{KIND_END, start_q, EndPartial};
              phase_d = PH_DONE;
            end else if (pleft_q == 32'd0) begin
              mal_d = 1'b1;
              phase_d = PH_SKIP;
              fin = 1'b1;
            end else if (pleft_q < 32'd5) begin
              mal_d = 1'b1;
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_OPCODE;
            end
          end else begin
            fcnt_d = 3'(hidx + 3'd1) & 3'd3;
          end
        end
      end
      default: begin
        pos_d = pos_q + 32'd1;
        crc_d = crc_step(crc_q, log_byte_i);
        pleft_d = pleft_q - 32'd1;
        sh = 32'(log_byte_i) << {fcnt_q[1:0], 3'd0};
        unique case (phase_q)
          PH_OPCODE: begin
            bundle_o.count = 2'd1;
            bundle_o.res[0] = '{KIND_OPCODE, 32'(log_byte_i), 2'd0};
            args_d = '0; fcnt_d = '0; phase_d = PH_NARGS;
          end
          PH_NARGS: begin
            args_d = args_q | sh;
            fcnt_d = fcnt_q + 3'd1;
            if (fcnt_q == 3'd3) begin
              fcnt_d = '0; abytes_d = '0;
              phase_d = (args_d != 32'd0) ? PH_ARGLEN : PH_SKIP;
            end
          end
          PH_ARGLEN: begin
            abytes_d = abytes_q | sh;
            fcnt_d = fcnt_q + 3'd1;
            if (fcnt_q == 3'd3) begin
              fcnt_d = '0;
              if (abytes_d > pleft_d) begin
                mal_d = 1'b1; phase_d = PH_SKIP;
              end else begin
                bundle_o.count = 2'd1;
                bundle_o.res[0] = '{KIND_ARGLEN, abytes_d, 2'd0};
                if (abytes_d == 32'd0) begin
                  args_d = args_q - 32'd1;
                  phase_d = (args_d != 32'd0) ? PH_ARGLEN : PH_SKIP;
                end else begin
                  phase_d = PH_ARGBYTE;
                end
              end
            end
          end
          PH_ARGBYTE: begin
            bundle_o.count = 2'd1;
            bundle_o.res[0] = '{KIND_ARGBYTE, 32'(log_byte_i), 2'd0};
            abytes_d = abytes_q - 32'd1;
            if (abytes_d == 32'd0) begin
              args_d = args_q - 32'd1;
              fcnt_d = '0;
              phase_d = (args_d != 32'd0) ? PH_ARGLEN : PH_SKIP;
            end
          end
          default: ;
        endcase
        fin = (pleft_d == 32'd0);
      end
    endcase
    if (fin) begin
      if ((crc_d ^ AllOnes) != stored_d) begin
        bundle_o.res[bundle_o.count] = '{KIND_VERDICT, 32'd0, VerdictCrcBad};
        bundle_o.res[bundle_o.count + 2'd1] = '{KIND_END, start_q, EndCrc};
        bundle_o.count = bundle_o.count + 2'd2;
        phase_d = PH_DONE;
      end else begin
        bundle_o.res[bundle_o.count] = '{KIND_VERDICT, 32'd0,
          (mal_d || phase_d == PH_OPCODE || phase_d == PH_NARGS || phase_d == PH_ARGLEN ||
           (phase_d == PH_ARGBYTE && abytes_d != 32'd0)) ? VerdictMalformed : VerdictOk};
        bundle_o.count = bundle_o.count + 2'd1;
        start_d = pos_d;
        pleft_d = '0; stored_d = '0; crc_d = AllOnes; args_d = '0; abytes_d = '0;
        fcnt_d = '0; mal_d = 1'b0; phase_d = PH_HEADER;
        rem = (pos_d < log_length_i) ? (log_length_i - pos_d) : 32'd0;
        if (rem < 32'd8) begin
          bundle_o.res[bundle_o.count] = '{KIND_END, log_length_i,
                                           (rem == 32'd0) ? EndClean : EndShortTail};
          bundle_o.count = bundle_o.count + 2'd1;
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; start_q <= '0; pleft_q <= '0; stored_q <= '0;
      crc_q <= AllOnes; args_q <= '0; abytes_q <= '0; fcnt_q <= '0; mal_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; pos_q <= pos_d; start_q <= start_d; pleft_q <= pleft_d;
      stored_q <= stored_d; crc_q <= crc_d; args_q <= args_d; abytes_q <= abytes_d;
      fcnt_q <= fcnt_d; mal_q <= mal_d;
    end
  end

endmodule

@@ rtl/core/lrd_back.sv @@
// Back end: queue of result bundles, unrolled one result per output word.
module lrd_back import lrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bundle_t     bundle_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     res_o,
  output logic        last_o
);

  bundle_t          mem_q [QDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QIdxW:0]   cnt_q;
  logic [1:0]       sub_q;
  logic             pop, adv;
  bundle_t          head;

  assign head = mem_q[rd_q];
  assign full_o = (cnt_q == (QIdxW+1)'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign res_o = head.res[sub_q];
  assign last_o = (sub_q == head.count - 2'd1);
  assign adv = out_valid_o && !out_stall_i;
  assign pop = adv && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QIdxW+1)'(push_i) - (QIdxW+1)'(pop);
      if (pop) sub_q <= '0;
      else if (adv) sub_q <= sub_q + 2'd1;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_no_overflow, !(push_i && full_o), "push into full queue")
  `ASSERT_CLK(a_sub_in_range, !out_valid_o || (sub_q < head.count), "sub index past bundle")
  `ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(sub_q),
    "stalled result moved")

endmodule

@@ rtl/core/log_record_deframer_crc_check_unit.sv @@
// Top level of the log record deframer with CRC-32 check.
// Usage:
//  - Input channel: one log byte per word on log_byte_i, taken when
//    in_valid_i is high and in_stall_o is low.
//  - Output channel: one result word per cycle (kind_o, value_o, status_o,
//    last_of_run_o), taken when out_valid_o is high and out_stall_i is low.
//  - log_length is written via cfg_we_i/cfg_wdata_i while the block is idle.
// Timing: a byte is classified and its CRC table step applied in the cycle
// it is taken; its results are registered into the bundle queue. A byte
// that causes no result uses no queue entry. Throughput is one byte per
// cycle while each byte causes at most one result and out_stall_i is low;
// the output port emits one result per cycle unless stalled, so a byte with
// two or three results holds the port until all are emitted. A four-entry
// bundle queue decouples the two sides; in_stall_o rises when it is full.
// Reset clears framing state, CRC (to all ones), queue and log_length.
// After a log end result every later byte is taken and dropped.
module log_record_deframer_crc_check_unit import lrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  log_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic        last_of_run_o
);

  logic [31:0] log_length_q;
  logic        take, full;
  bundle_t     bundle;
  result_t     res;

  // Hold log_length until rewritten.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) log_length_q <= '0;
    else if (cfg_we_i) log_length_q <= cfg_wdata_i;
  end

  assign in_stall_o = full;
  assign take = in_valid_i && !full;

  lrd_front u_front (
    .clk_i, .rst_ni, .log_length_i(log_length_q), .take_i(take),
    .log_byte_i, .bundle_o(bundle)
  );

  // Push only bundles that carry results.
  lrd_back u_back (
    .clk_i, .rst_ni, .push_i(take && bundle.count != 2'd0), .bundle_i(bundle),
    .full_o(full), .out_valid_o, .out_stall_i, .res_o(res), .last_o(last_of_run_o)
  );

  assign kind_o = res.kind;
  assign value_o = res.value;
  assign status_o = res.status;

endmodule
